// File: hw/rtl/qee_pkg.sv
// Shared types and constants of the quadrature encoder emulator.
package qee_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned REG_WIDTH       = 16;
    localparam int unsigned FIRE_DEPTH      = 4;

    localparam logic [REG_WIDTH-1:0] PERIOD_RST = 16'd10;
    localparam logic [REG_WIDTH-1:0] PHASE_RST  = 16'd2;
    localparam logic                 TWO_EDGE_RST = 1'b1;

    localparam logic [2:0] PIN_A   = 3'b001;
    localparam logic [2:0] PIN_B   = 3'b010;
    localparam logic [2:0] PIN_BTN = 3'b100;

    typedef enum logic [1:0] {
        CFG_PERIOD   = 2'd0,
        CFG_PHASE    = 2'd1,
        CFG_TWO_EDGE = 2'd2
    } t_cfg_idx;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_G1   = 12'b0000_0000_0010,
        S_G2   = 12'b0000_0000_0100,
        S_G3   = 12'b0000_0000_1000,
        S_G4   = 12'b0000_0001_0000,
        S_PH   = 12'b0000_0010_0000,
        S_P1   = 12'b0000_0100_0000,
        S_P2   = 12'b0000_1000_0000,
        S_P3   = 12'b0001_0000_0000,
        S_P4   = 12'b0010_0000_0000,
        S_P5   = 12'b0100_0000_0000,
        S_BR   = 12'b1000_0000_0000
    } t_step;

    typedef struct packed {
        logic        req_type;
        logic        turn_right;
        logic [15:0] pulse_count;
        logic        press_button;
    } t_in_req;

    typedef struct packed {
        logic drive_a;
        logic drive_b;
        logic drive_button;
        logic busy_res;
        logic command_refused;
    } t_out_res;

    typedef struct packed {
        t_step      step;
        logic [2:0] pins;
        logic       right;
        logic       press;
        logic       last_left;
    } t_ctl;

    typedef struct packed {
        logic [REG_WIDTH-1:0] period;
        logic [REG_WIDTH-1:0] phase;
        logic                 two_edge;
    } t_cfg;

endpackage

// File: hw/rtl/qee_fire.sv
// One firing stage of the turn sequencer: acts when the current wait has run out.
module qee_fire
    import qee_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  t_ctl                   i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_wait,
    input  logic [COUNT_WIDTH-1:0] i_pulses,
    input  logic [COUNT_WIDTH-1:0] i_period,
    input  logic [COUNT_WIDTH-1:0] i_phase,
    input  logic [COUNT_WIDTH-1:0] i_gap,
    input  logic                   i_two_edge,
    output t_ctl                   o_ctl,
    output logic [COUNT_WIDTH-1:0] o_wait,
    output logic [COUNT_WIDTH-1:0] o_pulses
);

    logic [2:0] w_lead;
    logic [2:0] w_trail;
    logic       w_check;

    assign w_lead  = i_ctl.right ? PIN_B : PIN_A;
    assign w_trail = i_ctl.right ? PIN_A : PIN_B;

    always_comb begin
        o_ctl    = i_ctl;
        o_wait   = i_wait;
        o_pulses = i_pulses;
        w_check  = 1'b0;
        if (i_ctl.step != S_IDLE && i_wait == '0) begin
            case (i_ctl.step)
                S_G1: begin
                    o_ctl.pins = i_ctl.pins | (i_ctl.right ? PIN_A : PIN_B);
                    o_ctl.step = S_G2;
                    o_wait     = i_period;
                end
                S_G2: begin
                    if (i_ctl.right) begin
                        o_ctl.pins = i_ctl.pins | PIN_B;
                        o_ctl.step = S_G3;
                        o_wait     = i_period;
                    end else begin
                        o_ctl.pins = i_ctl.pins & ~PIN_B;
                        o_ctl.step = S_PH;
                        o_wait     = i_phase;
                    end
                end
                S_G3: begin
                    o_ctl.pins = i_ctl.pins & ~PIN_B;
                    o_ctl.step = S_G4;
                    o_wait     = i_period;
                end
                S_G4: begin
                    o_ctl.pins = i_ctl.pins & ~PIN_A;
                    o_ctl.step = S_PH;
                    o_wait     = i_phase;
                end
                S_PH: begin
                    w_check = 1'b1;
                end
                S_P1: begin
                    o_ctl.pins = i_ctl.pins | w_lead;
                    o_ctl.step = S_P2;
                    o_wait     = i_phase;
                end
                S_P2: begin
                    o_ctl.pins = i_ctl.pins | w_trail;
                    o_ctl.step = S_P3;
                    o_wait     = i_gap;
                end
                S_P3: begin
                    if (i_two_edge) begin
                        o_ctl.pins = i_ctl.pins & ~w_lead;
                        o_ctl.step = S_P4;
                    end else begin
                        o_ctl.pins = i_ctl.pins & ~w_lead & ~w_trail;
                        o_ctl.step = S_P5;
                    end
                    o_wait = i_phase;
                end
                S_P4: begin
                    o_ctl.pins = i_ctl.pins & ~w_trail;
                    if (i_pulses != '0) begin
                        o_pulses = i_pulses - COUNT_WIDTH'(1);
                    end
                    w_check = 1'b1;
                end
                S_P5: begin
                    if (i_pulses != '0) begin
                        o_pulses = i_pulses - COUNT_WIDTH'(1);
                    end
                    w_check = 1'b1;
                end
                S_BR: begin
                    o_ctl.pins      = i_ctl.pins & ~PIN_BTN;
                    o_ctl.last_left = ~i_ctl.right;
                    o_ctl.step      = S_IDLE;
                    o_wait          = '0;
                end
                default: begin
                    o_ctl.last_left = ~i_ctl.right;
                    o_ctl.step      = S_IDLE;
                    o_wait          = '0;
                end
            endcase
            if (w_check) begin
                if (o_pulses != '0) begin
                    o_ctl.step = S_P1;
                    o_wait     = i_gap;
                end else if (i_ctl.press) begin
                    o_ctl.step = S_BR;
                    o_wait     = i_period;
                end else begin
                    o_ctl.last_left = ~i_ctl.right;
                    o_ctl.step      = S_IDLE;
                    o_wait          = '0;
                end
            end
        end
    end

endmodule

// File: hw/rtl/qee_core.sv
// Request register, sequencer state, firing stages and result register.
module qee_core
    import qee_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_res
);

    localparam logic [32:0] MaxCnt = (33'd1 << COUNT_WIDTH) - 33'd1;

    function automatic logic [COUNT_WIDTH-1:0] f_sat(input logic [REG_WIDTH-1:0] v);
        logic [32:0] wide;
        wide = {{(33-REG_WIDTH){1'b0}}, v};
        return (wide > MaxCnt) ? '1 : COUNT_WIDTH'(v);
    endfunction

    logic                   r_in_vld;
    t_in_req                r_in;
    logic                   r_out_vld;
    t_out_res               r_res;
    t_ctl                   r_ctl;
    logic [COUNT_WIDTH-1:0] r_wait;
    logic [COUNT_WIDTH-1:0] r_pulses;

    t_ctl                   n_ctl;
    logic [COUNT_WIDTH-1:0] n_wait;
    logic [COUNT_WIDTH-1:0] n_pulses;
    t_out_res               n_res;

    logic                   w_adv;
    logic                   w_busy;
    logic                   w_refuse;
    logic                   w_flat;
    logic [REG_WIDTH-1:0]   w_gap16;
    logic [COUNT_WIDTH-1:0] w_period;
    logic [COUNT_WIDTH-1:0] w_phase;
    logic [COUNT_WIDTH-1:0] w_gap;

    t_ctl                   w_ctl    [FIRE_DEPTH+1];
    logic [COUNT_WIDTH-1:0] w_wait   [FIRE_DEPTH+1];
    logic [COUNT_WIDTH-1:0] w_pulses [FIRE_DEPTH+1];

    assign w_adv       = ~r_out_vld | ~i_out_stall;
    assign o_in_stall  = r_in_vld & ~w_adv;
    assign o_out_valid = r_out_vld;
    assign o_res       = r_res;

    assign w_busy   = (r_ctl.step != S_IDLE);
    assign w_refuse = r_in.req_type & w_busy;
    assign w_flat   = (i_cfg.period == '0) && (i_cfg.phase == '0);
    assign w_gap16  = (i_cfg.phase > i_cfg.period) ? '0 : (i_cfg.period - i_cfg.phase);
    assign w_period = f_sat(i_cfg.period);
    assign w_phase  = f_sat(i_cfg.phase);
    assign w_gap    = f_sat(w_gap16);

    always_comb begin
        w_ctl[0]    = r_ctl;
        w_wait[0]   = r_wait;
        w_pulses[0] = r_pulses;
        if (r_in.req_type) begin
            if (!w_busy) begin
                w_ctl[0].right = r_in.turn_right;
                w_ctl[0].press = r_in.press_button;
                w_pulses[0]    = f_sat(r_in.pulse_count);
                if (r_in.press_button) begin
                    w_ctl[0].pins = r_ctl.pins | PIN_BTN;
                end
                if (r_in.turn_right == r_ctl.last_left) begin
                    w_ctl[0].step = S_G1;
                    w_wait[0]     = w_period;
                end else begin
                    w_ctl[0].step = S_PH;
                    w_wait[0]     = w_phase;
                end
            end
        end else if (w_busy && r_wait != '0) begin
            w_wait[0] = r_wait - COUNT_WIDTH'(1);
        end
    end

    for (genvar g = 0; g < FIRE_DEPTH; g++) begin : g_fire
        qee_fire #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_fire (
            .i_ctl      (w_ctl[g]),
            .i_wait     (w_wait[g]),
            .i_pulses   (w_pulses[g]),
            .i_period   (w_period),
            .i_phase    (w_phase),
            .i_gap      (w_gap),
            .i_two_edge (i_cfg.two_edge),
            .o_ctl      (w_ctl[g+1]),
            .o_wait     (w_wait[g+1]),
            .o_pulses   (w_pulses[g+1])
        );
    end

    always_comb begin
        n_ctl    = w_ctl[FIRE_DEPTH];
        n_wait   = w_wait[FIRE_DEPTH];
        n_pulses = w_pulses[FIRE_DEPTH];
        if (w_refuse) begin
            n_ctl    = r_ctl;
            n_wait   = r_wait;
            n_pulses = r_pulses;
        end else if (w_flat && w_ctl[0].step != S_IDLE && w_wait[0] == '0) begin
            n_ctl.pins      = '0;
            n_ctl.step      = S_IDLE;
            n_ctl.last_left = ~w_ctl[0].right;
            n_wait          = '0;
            n_pulses        = '0;
        end
        n_res.drive_a         = n_ctl.pins[0];
        n_res.drive_b         = n_ctl.pins[1];
        n_res.drive_button    = n_ctl.pins[2];
        n_res.busy_res        = (n_ctl.step != S_IDLE);
        n_res.command_refused = w_refuse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctl     <= '{step: S_IDLE, pins: '0, right: 1'b0, press: 1'b0,
                           last_left: 1'b0};
            r_wait    <= '0;
            r_pulses  <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (w_adv && r_in_vld) begin
                r_ctl    <= n_ctl;
                r_wait   <= n_wait;
                r_pulses <= n_pulses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_req;
        end
        if (w_adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

endmodule

// File: hw/rtl/quadrature_encoder_emulator_top.sv
// Top level of the quadrature encoder emulator: configuration registers and core.
//
// Requests enter on i_in_valid / o_in_stall with payload i_req; a request is
// taken at a clock edge where i_in_valid is high and o_in_stall is low. A tick
// request advances the turn sequence by one tick; a command request starts a
// turn, or is dropped and flagged when a turn is still running.
// Every request yields one result on o_out_valid / i_out_stall with payload
// o_res: the A, B and button pin drives after the request, the busy flag and
// the refused flag.
// A request is held in the request register, its result in the result register;
// one request per cycle is sustained while i_out_stall is low, set by the single
// sequencer state update per taken request.
// Configuration is written via i_cfg_we / i_cfg_idx / i_cfg_data, landing at the
// i_cfg_we edge; unenforced, the user must write only while no turn is running.
// Synchronous active-low reset clears both stages, releases all pins, idles
// the sequencer and loads the default period, phase and edge mode.
// While i_out_stall holds a waiting result, the request stage fills and then
// raises o_in_stall until the result is taken.
module quadrature_encoder_emulator_top
    import qee_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [REG_WIDTH-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_res             o_res
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period   <= PERIOD_RST;
            r_cfg.phase    <= PHASE_RST;
            r_cfg.two_edge <= TWO_EDGE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PERIOD:   r_cfg.period   <= i_cfg_data;
                CFG_PHASE:    r_cfg.phase    <= i_cfg_data;
                CFG_TWO_EDGE: r_cfg.two_edge <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    qee_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (o_res)
    );

endmodule

// File: hw/rtl/qee_checker.sv
// Port-level checks of the quadrature encoder emulator and their binding.
module qee_checker
    import qee_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_res             o_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_res))
        else $error("result changed while stalled");

    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_res.command_refused |-> o_res.busy_res)
        else $error("refused request reported while idle");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_res.busy_res |->
            !o_res.drive_a && !o_res.drive_b && !o_res.drive_button)
        else $error("pin driven while idle");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind quadrature_encoder_emulator_top qee_checker u_qee_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench of the quadrature encoder emulator: directed turns and random traffic.
module tb_top;
    import qee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_TURN = 1'b1;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TOTAL_ITEMS   = 1700;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [1:0]           i_cfg_idx  = '0;
    logic [REG_WIDTH-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_req              i_req      = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_res             o_res;

    quadrature_encoder_emulator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (i_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_res      (o_res)
    );

    always #5 i_clk = ~i_clk;

    // predicted sequencer state and registers
    t_step       sq_step      = S_IDLE;
    logic [15:0] sq_wait      = '0;
    logic [15:0] sq_pulses    = '0;
    logic [2:0]  sq_pins      = '0;
    logic        sq_last_left = 1'b0;
    logic        sq_right     = 1'b0;
    logic        sq_press     = 1'b0;
    logic [15:0] cf_period    = PERIOD_RST;
    logic [15:0] cf_phase     = PHASE_RST;
    logic        cf_two_edge  = TWO_EDGE_RST;

    t_out_res    pins_due[$];
    int unsigned n_err       = 0;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned stall_left  = 0;
    bit          in_idle     = 1'b1;
    bit          out_idle    = 1'b1;

    function automatic logic [15:0] gap_len();
        return (cf_phase > cf_period) ? 16'd0 : cf_period - cf_phase;
    endfunction

    function automatic void go_to(t_step s, logic [15:0] w);
        sq_step = s;
        sq_wait = w;
    endfunction

    function automatic void end_turn();
        sq_last_left = ~sq_right;
        sq_step      = S_IDLE;
        sq_wait      = '0;
    endfunction

    function automatic void next_pulse_or_end();
        if (sq_pulses != 0) begin
            go_to(S_P1, gap_len());
        end else if (sq_press) begin
            go_to(S_BR, cf_period);
        end else begin
            end_turn();
        end
    endfunction

    function automatic void count_pulse();
        if (sq_pulses != 0) begin
            sq_pulses--;
        end
        next_pulse_or_end();
    endfunction

    function automatic void fire_step();
        logic [2:0] lead;
        logic [2:0] trail;
        lead  = sq_right ? PIN_B : PIN_A;
        trail = sq_right ? PIN_A : PIN_B;
        case (sq_step)
            S_G1: begin
                sq_pins |= (sq_right ? PIN_A : PIN_B);
                go_to(S_G2, cf_period);
            end
            S_G2: begin
                if (sq_right) begin
                    sq_pins |= PIN_B;
                    go_to(S_G3, cf_period);
                end else begin
                    sq_pins &= ~PIN_B;
                    go_to(S_PH, cf_phase);
                end
            end
            S_G3: begin
                sq_pins &= ~PIN_B;
                go_to(S_G4, cf_period);
            end
            S_G4: begin
                sq_pins &= ~PIN_A;
                go_to(S_PH, cf_phase);
            end
            S_PH: begin
                next_pulse_or_end();
            end
            S_P1: begin
                sq_pins |= lead;
                go_to(S_P2, cf_phase);
            end
            S_P2: begin
                sq_pins |= trail;
                go_to(S_P3, gap_len());
            end
            S_P3: begin
                sq_pins &= ~lead;
                if (cf_two_edge) begin
                    go_to(S_P4, cf_phase);
                end else begin
                    sq_pins &= ~trail;
                    go_to(S_P5, cf_phase);
                end
            end
            S_P4: begin
                sq_pins &= ~trail;
                count_pulse();
            end
            S_P5: begin
                count_pulse();
            end
            S_BR: begin
                sq_pins &= ~PIN_BTN;
                end_turn();
            end
            default: begin
                end_turn();
            end
        endcase
    endfunction

    function automatic t_out_res predict_pins(t_in_req r);
        t_out_res res;
        logic     refused;
        refused = 1'b0;
        if (r.req_type == REQ_TURN) begin
            if (sq_step != S_IDLE) begin
                refused = 1'b1;
            end else begin
                sq_right  = r.turn_right;
                sq_press  = r.press_button;
                sq_pulses = r.pulse_count;
                if (sq_press) begin
                    sq_pins |= PIN_BTN;
                end
                if (sq_right == sq_last_left) begin
                    go_to(S_G1, cf_period);
                end else begin
                    go_to(S_PH, cf_phase);
                end
            end
        end else if (sq_step != S_IDLE && sq_wait != 0) begin
            sq_wait--;
        end
        while (sq_step != S_IDLE && sq_wait == 0) begin
            fire_step();
        end
        res.drive_a         = sq_pins[0];
        res.drive_b         = sq_pins[1];
        res.drive_button    = sq_pins[2];
        res.busy_res        = (sq_step != S_IDLE);
        res.command_refused = refused;
        return res;
    endfunction

    function automatic t_in_req make_req(logic kind, logic right, logic [15:0] cnt, logic press);
        t_in_req r;
        r.req_type     = kind;
        r.turn_right   = right;
        r.pulse_count  = cnt;
        r.press_button = press;
        return r;
    endfunction

    function automatic t_in_req tick_req();
        return make_req(REQ_TICK, 1'($urandom_range(0, 1)), 16'($urandom()),
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic flag_mismatch(string msg);
        n_err++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // leaves valid high after the accept so that back-to-back requests need no gap
    task automatic send_req(t_in_req r);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req      <= r;
        do @(posedge i_clk); while (o_in_stall);
        pins_due.push_back(predict_pins(r));
        n_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pins_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [15:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PERIOD:   cf_period   = val;
            CFG_PHASE:    cf_phase    = val;
            CFG_TWO_EDGE: cf_two_edge = val[0];
            default: ;
        endcase
    endtask

    task automatic run_turn(logic right, logic [15:0] cnt, logic press);
        send_req(make_req(REQ_TURN, right, cnt, press));
        while (sq_step != S_IDLE) send_req(tick_req());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pins_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %b", o_res));
            end else begin
                t_out_res want;
                want = pins_due.pop_front();
                if (o_res.drive_a !== want.drive_a)
                    flag_mismatch($sformatf("result %0d drive_a %b, want %b",
                                            n_checked, o_res.drive_a, want.drive_a));
                if (o_res.drive_b !== want.drive_b)
                    flag_mismatch($sformatf("result %0d drive_b %b, want %b",
                                            n_checked, o_res.drive_b, want.drive_b));
                if (o_res.drive_button !== want.drive_button)
                    flag_mismatch($sformatf("result %0d drive_button %b, want %b",
                                            n_checked, o_res.drive_button, want.drive_button));
                if (o_res.busy_res !== want.busy_res)
                    flag_mismatch($sformatf("result %0d busy_res %b, want %b",
                                            n_checked, o_res.busy_res, want.busy_res));
                if (o_res.command_refused !== want.command_refused)
                    flag_mismatch($sformatf("result %0d command_refused %b, want %b",
                                            n_checked, o_res.command_refused,
                                            want.command_refused));
            end
            n_checked++;
            stall_left = out_idle ? $urandom_range(0, 6) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    task automatic test_default_turns();
        send_req(tick_req());
        send_req(tick_req());
        run_turn(1'b0, 16'd2, 1'b1);
        run_turn(1'b1, 16'd2, 1'b1);
        run_turn(1'b1, 16'd1, 1'b0);
    endtask

    task automatic test_refused_command();
        send_req(make_req(REQ_TURN, 1'b0, 16'd1, 1'b0));
        send_req(make_req(REQ_TURN, 1'b1, 16'hFFFF, 1'b1));
        send_req(make_req(REQ_TURN, 1'b0, 16'h0000, 1'b0));
        while (sq_step != S_IDLE) send_req(tick_req());
    endtask

    task automatic test_edge_modes();
        write_cfg(CFG_TWO_EDGE, 16'd0);
        run_turn(1'b1, 16'd2, 1'b0);
        run_turn(1'b0, 16'd2, 1'b1);
        write_cfg(CFG_TWO_EDGE, 16'd1);
        run_turn(1'b0, 16'd1, 1'b0);
    endtask

    task automatic test_zero_pulses();
        run_turn(1'b1, 16'd0, 1'b1);
        run_turn(1'b0, 16'd0, 1'b0);
        run_turn(1'b0, 16'd0, 1'b1);
    endtask

    task automatic test_phase_over_period();
        write_cfg(CFG_PERIOD, 16'd3);
        write_cfg(CFG_PHASE, 16'd5);
        run_turn(1'b1, 16'd2, 1'b1);
        write_cfg(CFG_PERIOD, 16'd1);
        write_cfg(CFG_PHASE, 16'd1);
        run_turn(1'b1, 16'd3, 1'b0);
        write_cfg(CFG_PHASE, 16'd0);
        run_turn(1'b0, 16'd2, 1'b1);
        write_cfg(CFG_PERIOD, 16'd0);
        write_cfg(CFG_PHASE, 16'd3);
        run_turn(1'b1, 16'd2, 1'b1);
        write_cfg(CFG_PHASE, 16'd0);
        run_turn(1'b0, 16'd5, 1'b1);
    endtask

    task automatic test_long_turns();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        write_cfg(CFG_PERIOD, 16'd1);
        write_cfg(CFG_PHASE, 16'd0);
        run_turn(1'b0, 16'd60, 1'b1);
        write_cfg(CFG_PERIOD, 16'd120);
        write_cfg(CFG_PHASE, 16'd120);
        run_turn(1'b0, 16'd0, 1'b0);
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned turns;
        int unsigned stop_at;
        logic [15:0] cnt;
        turns   = 0;
        stop_at = TOTAL_ITEMS;
        while (n_sent < stop_at) begin
            if (turns % 5 == 0) begin
                write_cfg(CFG_PERIOD, 16'($urandom_range(1, 12)));
                write_cfg(CFG_PHASE, 16'($urandom_range(0, 14)));
                write_cfg(CFG_TWO_EDGE, 16'($urandom_range(0, 1)));
            end
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_req(tick_req());
            end
            cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 12))
                                              : 16'($urandom_range(0, 4));
            send_req(make_req(REQ_TURN, 1'($urandom_range(0, 1)), cnt,
                              1'($urandom_range(0, 1))));
            while (sq_step != S_IDLE) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_req(make_req(REQ_TURN, 1'($urandom_range(0, 1)), 16'($urandom()),
                                      1'($urandom_range(0, 1))));
                end
                send_req(tick_req());
            end
            turns++;
        end
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_turns();
        test_refused_command();
        test_edge_modes();
        test_zero_pulses();
        test_phase_over_period();
        test_long_turns();
        test_random_traffic();
        settle();
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/qee_pkg.sv
hw/rtl/qee_fire.sv
hw/rtl/qee_core.sv
hw/rtl/quadrature_encoder_emulator_top.sv
hw/rtl/qee_checker.sv
tb/tb_top.sv
